/* src/ipac_pkg.sv */
// Shared types and constants for the IP prefix access check block.
`timescale 1ns / 1ps
`default_nettype none
package ipac_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

  // One table slot as stored in memory; the valid mark lives in flip-flops.
  typedef struct packed {
    logic        family;
    logic [63:0] net_high;
    logic [63:0] net_low;
    logic [7:0]  prefix;
  } slot_t;

endpackage
`default_nettype wire

/* src/ipac_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ipac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [ADDR_W-1:0]      wr_addr,
  input  wire logic [WIDTH-1:0]       wr_data,
  input  wire logic                   rd_en,
  input  wire logic [ADDR_W-1:0]      rd_addr,
  output logic      [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/ipac_match.sv */
// Prefix compare of one table slot against the request, with hit accumulation.
`timescale 1ns / 1ps
`default_nettype none
module ipac_match
  import ipac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        clear,
  input  wire logic        en,
  input  wire logic        slot_valid,
  input  wire slot_t       slot,
  input  wire logic [1:0]  req_family,
  input  wire logic [63:0] req_high,
  input  wire logic [63:0] req_low,
  output logic             hit
);

  logic         acc;
  logic [31:0]  mask32;
  logic [127:0] mask128;
  logic         v4_hit;
  logic         v6_hit;
  logic         entry_hit;

  // The mask keeps the prefix bits, counted from the most significant bit.
  assign mask32  = ~(32'hFFFF_FFFF >> slot.prefix);
  assign mask128 = ~({128{1'b1}} >> slot.prefix);

  assign v4_hit = (slot.prefix <= V4_MAX_PREFIX) &&
                  (((req_low[31:0] ^ slot.net_low[31:0]) & mask32) == 32'd0);
  assign v6_hit = (slot.prefix <= V6_MAX_PREFIX) &&
                  ((({req_high, req_low} ^ {slot.net_high, slot.net_low}) & mask128)
                   == 128'd0);

  always_comb begin
    entry_hit = 1'b0;
    if (slot_valid && (slot.family == req_family[0])) begin
      if (req_family == FAM_IPV4) begin
        entry_hit = v4_hit;
      end else begin
        entry_hit = v6_hit;
      end
    end
  end

  assign hit = acc | (en & entry_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 1'b0;
    end else if (clear) begin
      acc <= 1'b0;
    end else if (en) begin
      acc <= hit;
    end
  end

endmodule
`default_nettype wire

/* src/ip_prefix_access_check.sv */
// Top level of the IP prefix access check: table memory, scan control, output register.
// A write beat updates one table slot without leaving the idle state and produces no
// result. A check beat walks the whole table, one slot read from the table memory per
// cycle, so it holds the input side through the scan, drain and done states, and longer
// while an earlier result beat is still stalled; its result beat is loaded into the output
// register from the done state. A check of an unknown family skips the walk and goes
// straight to the done state. The table memory has a single read port, so the walk reads
// one slot at a time. Valid marks are cleared by reset at once, so the block is ready in
// the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module ip_prefix_access_check
  import ipac_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [3:0]  entry_index,
  input  wire logic        entry_enable,
  input  wire logic [1:0]  family,
  input  wire logic [63:0] addr_high,
  input  wire logic [63:0] addr_low,
  input  wire logic [7:0]  prefix_len,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             allowed
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [IDX_W-1:0]         cnt;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     cmp_valid;
  logic                     cmp_last;
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [1:0]               req_family;
  logic [63:0]              req_high;
  logic [63:0]              req_low;
  logic                     result;
  logic                     hit;
  logic                     accept;
  logic                     ram_we;
  logic [IDX_W-1:0]         wr_addr;
  slot_t                    wr_slot;
  slot_t                    rd_slot;
  logic                     scan_rd;
  logic                     family_known;

  assign in_stall     = (state != ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign family_known = (family == FAM_IPV4) || (family == FAM_IPV6);
  // Writes to slots beyond the table are dropped.
  assign ram_we  = accept && (kind == KIND_WRITE) &&
                   ({28'd0, entry_index} < 32'(TABLE_ENTRIES));
  assign wr_addr = IDX_W'(entry_index);
  assign scan_rd = (state == ST_SCAN);

  always_comb begin
    wr_slot.family   = family[0];
    wr_slot.net_high = addr_high;
    wr_slot.net_low  = addr_low;
    wr_slot.prefix   = prefix_len;
  end

  ipac_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (scan_rd),
    .rd_addr (cnt),
    .rd_data (rd_slot)
  );

  ipac_match u_match (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .en         (cmp_valid),
    .slot_valid (slot_valid[cmp_idx]),
    .slot       (rd_slot),
    .req_family (req_family),
    .req_high   (req_high),
    .req_low    (req_low),
    .hit        (hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_CHECK)) begin
          state_next = family_known ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      cmp_valid  <= 1'b0;
      cmp_last   <= 1'b0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= scan_rd;
      cmp_last  <= scan_rd && (cnt == LAST_IDX);
      if (accept) begin
        cnt <= '0;
      end else if (scan_rd) begin
        cnt <= cnt + 1'b1;
      end
      if (ram_we) begin
        slot_valid[wr_addr] <= entry_enable && family_known;
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
    if (accept) begin
      req_family <= family;
      req_high   <= addr_high;
      req_low    <= addr_low;
      result     <= 1'b0;
    end else if (state == ST_DRAIN) begin
      result <= hit;
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      allowed <= result;
    end
  end

  // A result beat only starts from the final state of a check.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside the done state");

  // Compares come in the cycle after the table reads.
  a_cmp_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> $past(state) == ST_SCAN)
    else $error("compare without a preceding table read");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (cmp_valid && cmp_last))
    else $error("drain reached before the last slot was compared");

  a_unknown_family: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_CHECK) && !family_known) |=> (state == ST_DONE))
    else $error("check of unknown family did not skip the table walk");

endmodule
`default_nettype wire
